@@ src/bcc_pkg.sv @@
// shared types and constants for the coulomb counter
`timescale 1ns / 1ps
package bcc_pkg;

    // field and store widths
    localparam int CHG_W  = 38;
    localparam int INC_W  = 28;
    localparam int FILT_W = 24;
    localparam int TICK_W = 13;

    // shared divider sizes
    localparam int DIV_N_W = 46;
    localparam int DIV_D_W = 40;
    localparam int DIV_Q_W = 31;
    localparam int DIV_C_W = 5;

    // iteration counts: percent quotient stays below 128, minutes below 2^31
    localparam logic [DIV_C_W-1:0] PCT_ITERS = 5'd7;
    localparam logic [DIV_C_W-1:0] MIN_ITERS = 5'd31;

    // fixed-point constants
    localparam logic [21:0] MAH_UNITS   = 22'd3600000;
    localparam logic [15:0] MS_PER_MIN  = 16'd60000;
    localparam logic [6:0]  PCT_FULL    = 7'd100;
    localparam logic [TICK_W-1:0] TICK_MAX = 13'd8191;
    localparam logic [TICK_W-1:0] DT_MAX   = 13'd5000;
    localparam logic [15:0] EFF_ONE     = 16'd32768;
    localparam logic [7:0]  ALPHA_MIN   = 8'd26;
    localparam logic [7:0]  ALPHA_MAX   = 8'd251;
    localparam logic [INC_W-1:0] INC_MAX = 28'd163840000;

    // register reset values
    localparam logic [15:0] CAPACITY_RST = 16'd2000;
    localparam logic [7:0]  ALPHA_RST    = 8'd205;
    localparam logic [9:0]  DEAD_ZONE_RST = 10'd20;
    localparam logic [15:0] DIS_EFF_RST  = 16'd32768;
    localparam logic [15:0] CHG_EFF_RST  = 16'd31785;
    localparam logic [CHG_W-1:0] REMAIN_RST = 38'd7200000000;

    typedef enum logic [1:0] {
        ACT_TICK,
        ACT_SAMPLE,
        ACT_RESET,
        ACT_SET
    } action_t;

    typedef enum logic [2:0] {
        CFG_CAPACITY,
        CFG_ALPHA,
        CFG_DEAD_ZONE,
        CFG_DIS_EFF,
        CFG_CHG_EFF,
        CFG_CHG_EN
    } cfg_index_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_TICK,
        OP_RESET,
        OP_SET_A,
        OP_SET_B,
        OP_FIRST,
        OP_FILT_A,
        OP_FILT_B,
        OP_FILT_C,
        OP_INC_A,
        OP_INC_B,
        OP_APPLY,
        OP_CLAMP,
        OP_PCT_GO,
        OP_PCT_WAIT,
        OP_MIN_GO,
        OP_MIN_WAIT,
        OP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_TICK,
        ST_RESET,
        ST_SET_A,
        ST_SET_B,
        ST_FIRST,
        ST_FILT_A,
        ST_FILT_B,
        ST_FILT_C,
        ST_INC_A,
        ST_INC_B,
        ST_APPLY,
        ST_CLAMP,
        ST_PCT_GO,
        ST_PCT_WAIT,
        ST_MIN_GO,
        ST_MIN_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        action_t action;
        logic    awaiting_first;
        logic    dt_zero;
        logic    div_done;
        logic    out_free;
    } dp_status_t;

endpackage

@@ src/bcc_div.sv @@
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module bcc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bcc_pkg::DIV_N_W-1:0]  dividend,
    input  logic [bcc_pkg::DIV_D_W-1:0]  divisor,
    input  logic [bcc_pkg::DIV_C_W-1:0]  iters,
    output logic                         done,
    output logic [bcc_pkg::DIV_Q_W-1:0]  quotient
);

    logic [bcc_pkg::DIV_D_W-1:0] rem_reg;
    logic [bcc_pkg::DIV_D_W-1:0] dsr_reg;
    logic [bcc_pkg::DIV_N_W-1:0] shift_reg;
    logic [bcc_pkg::DIV_Q_W-1:0] q_reg;
    logic [bcc_pkg::DIV_C_W-1:0] cnt_reg;
    logic                        done_reg;
    logic [bcc_pkg::DIV_D_W:0]   trial;
    logic [bcc_pkg::DIV_D_W:0]   diff;
    logic                        ge;
    logic [bcc_pkg::DIV_C_W:0]   low_shift;

    // trial subtract of the next remainder bit
    assign trial     = {rem_reg, shift_reg[bcc_pkg::DIV_N_W-1]};
    assign diff      = trial - {1'b0, dsr_reg};
    assign ge        = (trial >= {1'b0, dsr_reg});
    assign low_shift = 6'(bcc_pkg::DIV_N_W) - {1'b0, iters};

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= iters;
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == 5'd1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= bcc_pkg::DIV_D_W'(dividend >> iters);
            shift_reg <= dividend << low_shift;
            dsr_reg   <= divisor;
            q_reg     <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg   <= ge ? diff[bcc_pkg::DIV_D_W-1:0] : trial[bcc_pkg::DIV_D_W-1:0];
            shift_reg <= shift_reg << 1;
            q_reg     <= {q_reg[bcc_pkg::DIV_Q_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

`ifndef ASSERT_OFF
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done lasted more than one cycle");
    a_start_count: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (cnt_reg == $past(iters)))
        else $error("divider did not load its iteration count");
`endif

endmodule

@@ src/bcc_datapath.sv @@
// datapath: configuration, stores, filter, integration and readout
`timescale 1ns / 1ps
module bcc_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bcc_pkg::dp_cmd_t             cmd,
    output bcc_pkg::dp_status_t          status,
    input  logic [1:0]                   action,
    input  logic [15:0]                  voltage_mv,
    input  logic signed [15:0]           current_ma,
    input  logic [15:0]                  elapsed_ms,
    input  logic [15:0]                  set_value_mah,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [15:0]                  cfg_data,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic                         integrated,
    output logic [bcc_pkg::CHG_W-1:0]    remaining_charge,
    output logic [bcc_pkg::CHG_W-1:0]    consumed_charge,
    output logic [bcc_pkg::INC_W-1:0]    last_increment,
    output logic [6:0]                   percent_left,
    output logic signed [15:0]           minutes_left,
    output logic [15:0]                  voltage_out_mv,
    output logic signed [15:0]           current_out_ma
);

    // configuration registers
    logic [15:0] capacity_reg;
    logic [7:0]  alpha_reg;
    logic [9:0]  dz_reg;
    logic [15:0] deff_reg;
    logic [15:0] ceff_reg;
    logic        chg_en_reg;

    // persistent state
    logic                              awaiting_reg;
    logic signed [bcc_pkg::FILT_W-1:0] filt_reg;
    logic [bcc_pkg::CHG_W-1:0]         remain_reg;
    logic [bcc_pkg::CHG_W-1:0]         consumed_reg;
    logic [bcc_pkg::INC_W-1:0]         incr_reg;
    logic [bcc_pkg::TICK_W-1:0]        tick_reg;
    logic [15:0]                       volt_hold_reg;
    logic [15:0]                       cur_hold_reg;
    logic                              integ_reg;
    logic [6:0]                        pct_reg;
    logic [15:0]                       min_reg;

    // latched transaction and scratch
    bcc_pkg::action_t                  act_reg;
    logic [15:0]                       volt_in_reg;
    logic signed [15:0]                cur_in_reg;
    logic [15:0]                       elapsed_reg;
    logic [15:0]                       set_in_reg;
    logic [bcc_pkg::CHG_W-1:0]         cap_reg;
    logic signed [32:0]                prod_a_reg;
    logic signed [33:0]                prod_b_reg;
    logic [39:0]                       prodm_reg;
    logic [bcc_pkg::INC_W-1:0]         inc_reg;

    // output register
    logic                              out_valid_reg;
    logic                              o_integ_reg;
    logic [bcc_pkg::CHG_W-1:0]         o_remain_reg;
    logic [bcc_pkg::CHG_W-1:0]         o_consumed_reg;
    logic [bcc_pkg::INC_W-1:0]         o_incr_reg;
    logic [6:0]                        o_pct_reg;
    logic [15:0]                       o_min_reg;
    logic [15:0]                       o_volt_reg;
    logic [15:0]                       o_cur_reg;

    // combinational helpers
    logic [bcc_pkg::CHG_W-1:0]         cap_calc;
    logic [15:0]                       dt_raw;
    logic [bcc_pkg::TICK_W-1:0]        dt_clamp;
    logic [bcc_pkg::FILT_W-1:0]        mag;
    logic [17:0]                       dz_q8;
    logic                              f_pos;
    logic                              f_neg;
    logic                              do_int;
    logic [15:0]                       eff_sel;
    logic [8:0]                        wgt;
    logic signed [32:0]                fa;
    logic signed [33:0]                fb;
    logic signed [33:0]                fsum;
    logic [52:0]                       inc_full;
    logic [bcc_pkg::CHG_W-1:0]         set_val;
    logic [bcc_pkg::CHG_W-1:0]         set_min;
    logic [7:0]                        alpha_wr;
    logic [15:0]                       eff_wr;
    logic                              div_start;
    logic [bcc_pkg::DIV_N_W-1:0]       div_dividend;
    logic [bcc_pkg::DIV_D_W-1:0]       div_divisor;
    logic [bcc_pkg::DIV_C_W-1:0]       div_iters;
    logic                              div_done;
    logic [bcc_pkg::DIV_Q_W-1:0]       div_q;
    logic [15:0]                       min_calc;
    logic [6:0]                        pct_calc;

    // capacity in charge units and elapsed time
    assign cap_calc = bcc_pkg::CHG_W'(capacity_reg) * bcc_pkg::CHG_W'(bcc_pkg::MAH_UNITS);
    assign dt_raw   = (elapsed_reg != 16'd0) ? elapsed_reg : 16'(tick_reg);
    assign dt_clamp = (dt_raw > 16'(bcc_pkg::DT_MAX)) ? bcc_pkg::DT_MAX
                                                       : dt_raw[bcc_pkg::TICK_W-1:0];

    // filtered current magnitude and dead zone decision
    assign mag     = filt_reg[bcc_pkg::FILT_W-1] ? 24'(-filt_reg) : 24'(filt_reg);
    assign dz_q8   = {dz_reg, 8'd0};
    assign f_pos   = (filt_reg > 0);
    assign f_neg   = filt_reg[bcc_pkg::FILT_W-1];
    assign do_int  = (mag > 24'(dz_q8)) && (f_pos || (f_neg && chg_en_reg));
    assign eff_sel = f_pos ? deff_reg : ceff_reg;

    // filter products and sum
    assign wgt  = 9'd256 - {1'b0, alpha_reg};
    assign fa   = $signed({25'd0, alpha_reg}) * 33'(filt_reg);
    assign fb   = ($signed({25'd0, wgt}) * 34'(cur_in_reg)) <<< 8;
    assign fsum = 34'(prod_a_reg) + prod_b_reg + 34'sd128;

    // increment from magnitude, efficiency and time
    assign inc_full = 53'(prodm_reg) * 53'(dt_clamp);

    // set remaining
    assign set_val = prodm_reg[bcc_pkg::CHG_W-1:0];
    assign set_min = (set_val > cap_reg) ? cap_reg : set_val;

    // config write clamps
    assign alpha_wr = (cfg_data[7:0] < bcc_pkg::ALPHA_MIN) ? bcc_pkg::ALPHA_MIN :
                      (cfg_data[7:0] > bcc_pkg::ALPHA_MAX) ? bcc_pkg::ALPHA_MAX : cfg_data[7:0];
    assign eff_wr   = (cfg_data > bcc_pkg::EFF_ONE) ? bcc_pkg::EFF_ONE : cfg_data;

    // divider operands
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = bcc_pkg::DIV_N_W'(remain_reg) * bcc_pkg::DIV_N_W'(bcc_pkg::PCT_FULL);
        div_divisor  = bcc_pkg::DIV_D_W'(cap_reg);
        div_iters    = bcc_pkg::PCT_ITERS;
        case (cmd.op)
            bcc_pkg::OP_PCT_GO:
            begin
                div_start = 1'b1;
            end
            bcc_pkg::OP_MIN_GO:
            begin
                div_start    = 1'b1;
                div_dividend = {remain_reg, 8'd0};
                div_divisor  = bcc_pkg::DIV_D_W'(mag) * bcc_pkg::DIV_D_W'(bcc_pkg::MS_PER_MIN);
                div_iters    = bcc_pkg::MIN_ITERS;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    bcc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .iters    (div_iters),
        .done     (div_done),
        .quotient (div_q)
    );

    // readout from the quotient
    always_comb
    begin
        if (cap_reg == '0)
            pct_calc = 7'd0;
        else if (remain_reg >= cap_reg)
            pct_calc = bcc_pkg::PCT_FULL;
        else
            pct_calc = div_q[6:0];

        if ((mag == '0) || (mag < 24'(dz_q8)))
            min_calc = 16'hFFFF;
        else if (f_pos)
            min_calc = (div_q > 31'd32767) ? 16'h7FFF : div_q[15:0];
        else
            min_calc = (div_q > 31'd32768) ? 16'h8000 : (16'd0 - div_q[15:0]);
    end

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= bcc_pkg::CAPACITY_RST;
            alpha_reg    <= bcc_pkg::ALPHA_RST;
            dz_reg       <= bcc_pkg::DEAD_ZONE_RST;
            deff_reg     <= bcc_pkg::DIS_EFF_RST;
            ceff_reg     <= bcc_pkg::CHG_EFF_RST;
            chg_en_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (bcc_pkg::cfg_index_t'(cfg_index))
                bcc_pkg::CFG_CAPACITY:  capacity_reg <= cfg_data;
                bcc_pkg::CFG_ALPHA:     alpha_reg    <= alpha_wr;
                bcc_pkg::CFG_DEAD_ZONE: dz_reg       <= cfg_data[9:0];
                bcc_pkg::CFG_DIS_EFF:   deff_reg     <= eff_wr;
                bcc_pkg::CFG_CHG_EFF:   ceff_reg     <= eff_wr;
                bcc_pkg::CFG_CHG_EN:    chg_en_reg   <= cfg_data[0];
                default:                chg_en_reg   <= chg_en_reg;
            endcase
        end
    end

    // stores and held sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg  <= 1'b1;
            filt_reg      <= '0;
            remain_reg    <= bcc_pkg::REMAIN_RST;
            consumed_reg  <= '0;
            incr_reg      <= '0;
            tick_reg      <= '0;
            volt_hold_reg <= '0;
            cur_hold_reg  <= '0;
            integ_reg     <= 1'b0;
            pct_reg       <= '0;
            min_reg       <= '0;
        end
        else
        begin
            case (cmd.op)
                bcc_pkg::OP_LOAD:
                begin
                    integ_reg <= 1'b0;
                end
                bcc_pkg::OP_TICK:
                begin
                    if (tick_reg < bcc_pkg::TICK_MAX)
                        tick_reg <= tick_reg + 1'b1;
                end
                bcc_pkg::OP_RESET:
                begin
                    remain_reg   <= cap_reg;
                    consumed_reg <= '0;
                    incr_reg     <= '0;
                    tick_reg     <= '0;
                    awaiting_reg <= 1'b1;
                end
                bcc_pkg::OP_SET_B:
                begin
                    remain_reg   <= set_min;
                    consumed_reg <= cap_reg - set_min;
                end
                bcc_pkg::OP_FIRST:
                begin
                    filt_reg      <= {cur_in_reg, 8'd0};
                    volt_hold_reg <= volt_in_reg;
                    cur_hold_reg  <= cur_in_reg;
                    incr_reg      <= '0;
                    tick_reg      <= '0;
                    awaiting_reg  <= 1'b0;
                end
                bcc_pkg::OP_FILT_C:
                begin
                    filt_reg <= fsum[31:8];
                end
                bcc_pkg::OP_APPLY:
                begin
                    if (f_pos)
                    begin
                        remain_reg   <= (remain_reg > bcc_pkg::CHG_W'(inc_reg))
                                        ? remain_reg - bcc_pkg::CHG_W'(inc_reg) : '0;
                        consumed_reg <= consumed_reg + bcc_pkg::CHG_W'(inc_reg);
                    end
                    else
                    begin
                        remain_reg <= remain_reg + bcc_pkg::CHG_W'(inc_reg);
                    end
                    incr_reg      <= inc_reg;
                    volt_hold_reg <= volt_in_reg;
                    cur_hold_reg  <= cur_in_reg;
                    tick_reg      <= '0;
                    integ_reg     <= 1'b1;
                end
                bcc_pkg::OP_CLAMP:
                begin
                    if (remain_reg > cap_reg)
                        remain_reg <= cap_reg;
                    if (consumed_reg > cap_reg)
                        consumed_reg <= cap_reg;
                end
                bcc_pkg::OP_PCT_WAIT:
                begin
                    if (div_done)
                        pct_reg <= pct_calc;
                end
                bcc_pkg::OP_MIN_WAIT:
                begin
                    if (div_done)
                        min_reg <= min_calc;
                end
                default:
                begin
                    integ_reg <= integ_reg;
                end
            endcase
        end
    end

    // latched transaction and scratch products
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            bcc_pkg::OP_LOAD:
            begin
                act_reg     <= bcc_pkg::action_t'(action);
                volt_in_reg <= voltage_mv;
                cur_in_reg  <= current_ma;
                elapsed_reg <= elapsed_ms;
                set_in_reg  <= set_value_mah;
                cap_reg     <= cap_calc;
            end
            bcc_pkg::OP_SET_A:
            begin
                prodm_reg <= 40'(set_in_reg) * 40'(bcc_pkg::MAH_UNITS);
            end
            bcc_pkg::OP_FILT_A:
            begin
                prod_a_reg <= fa;
            end
            bcc_pkg::OP_FILT_B:
            begin
                prod_b_reg <= fb;
            end
            bcc_pkg::OP_INC_A:
            begin
                prodm_reg <= do_int ? (40'(mag) * 40'(eff_sel)) : '0;
            end
            bcc_pkg::OP_INC_B:
            begin
                inc_reg <= inc_full[50:23];
            end
            default:
            begin
                inc_reg <= inc_reg;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == bcc_pkg::OP_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == bcc_pkg::OP_OUT)
        begin
            o_integ_reg    <= integ_reg;
            o_remain_reg   <= remain_reg;
            o_consumed_reg <= consumed_reg;
            o_incr_reg     <= incr_reg;
            o_pct_reg      <= pct_reg;
            o_min_reg      <= min_reg;
            o_volt_reg     <= volt_hold_reg;
            o_cur_reg      <= cur_hold_reg;
        end
    end

    // status to the controller
    assign status.action         = act_reg;
    assign status.awaiting_first = awaiting_reg;
    assign status.dt_zero        = (dt_raw == 16'd0);
    assign status.div_done       = div_done;
    assign status.out_free       = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign integrated       = o_integ_reg;
    assign remaining_charge = o_remain_reg;
    assign consumed_charge  = o_consumed_reg;
    assign last_increment   = o_incr_reg;
    assign percent_left     = o_pct_reg;
    assign minutes_left     = o_min_reg;
    assign voltage_out_mv   = o_volt_reg;
    assign current_out_ma   = o_cur_reg;

`ifndef ASSERT_OFF
    a_incr_range: assert property (@(posedge clk) disable iff (!rst_n)
        incr_reg <= bcc_pkg::INC_MAX)
        else $error("increment beyond its largest possible value");
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (o_pct_reg <= bcc_pkg::PCT_FULL))
        else $error("percent left above full");
`endif

endmodule

@@ src/bcc_ctrl.sv @@
// controller: sequences the datapath for each transaction
`timescale 1ns / 1ps
module bcc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bcc_pkg::dp_status_t  status,
    output bcc_pkg::dp_cmd_t     cmd
);

    bcc_pkg::state_t state_reg;
    bcc_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bcc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bcc_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = bcc_pkg::ST_DISPATCH;
            end
            bcc_pkg::ST_DISPATCH:
            begin
                case (status.action)
                    bcc_pkg::ACT_TICK:  state_next = bcc_pkg::ST_TICK;
                    bcc_pkg::ACT_RESET: state_next = bcc_pkg::ST_RESET;
                    bcc_pkg::ACT_SET:   state_next = bcc_pkg::ST_SET_A;
                    default:
                    begin
                        if (status.awaiting_first)
                            state_next = bcc_pkg::ST_FIRST;
                        else if (status.dt_zero)
                            state_next = bcc_pkg::ST_PCT_GO;
                        else
                            state_next = bcc_pkg::ST_FILT_A;
                    end
                endcase
            end
            bcc_pkg::ST_SET_A:  state_next = bcc_pkg::ST_SET_B;
            bcc_pkg::ST_FILT_A: state_next = bcc_pkg::ST_FILT_B;
            bcc_pkg::ST_FILT_B: state_next = bcc_pkg::ST_FILT_C;
            bcc_pkg::ST_FILT_C: state_next = bcc_pkg::ST_INC_A;
            bcc_pkg::ST_INC_A:  state_next = bcc_pkg::ST_INC_B;
            bcc_pkg::ST_INC_B:  state_next = bcc_pkg::ST_APPLY;
            bcc_pkg::ST_APPLY:  state_next = bcc_pkg::ST_CLAMP;
            bcc_pkg::ST_TICK, bcc_pkg::ST_RESET, bcc_pkg::ST_SET_B,
            bcc_pkg::ST_FIRST, bcc_pkg::ST_CLAMP:
            begin
                state_next = bcc_pkg::ST_PCT_GO;
            end
            bcc_pkg::ST_PCT_GO: state_next = bcc_pkg::ST_PCT_WAIT;
            bcc_pkg::ST_PCT_WAIT:
            begin
                if (status.div_done)
                    state_next = bcc_pkg::ST_MIN_GO;
            end
            bcc_pkg::ST_MIN_GO: state_next = bcc_pkg::ST_MIN_WAIT;
            bcc_pkg::ST_MIN_WAIT:
            begin
                if (status.div_done)
                    state_next = bcc_pkg::ST_OUT;
            end
            bcc_pkg::ST_OUT:
            begin
                if (status.out_free)
                    state_next = bcc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bcc_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = bcc_pkg::OP_NONE;
        case (state_reg)
            bcc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = bcc_pkg::OP_LOAD;
            end
            bcc_pkg::ST_TICK:     cmd.op = bcc_pkg::OP_TICK;
            bcc_pkg::ST_RESET:    cmd.op = bcc_pkg::OP_RESET;
            bcc_pkg::ST_SET_A:    cmd.op = bcc_pkg::OP_SET_A;
            bcc_pkg::ST_SET_B:    cmd.op = bcc_pkg::OP_SET_B;
            bcc_pkg::ST_FIRST:    cmd.op = bcc_pkg::OP_FIRST;
            bcc_pkg::ST_FILT_A:   cmd.op = bcc_pkg::OP_FILT_A;
            bcc_pkg::ST_FILT_B:   cmd.op = bcc_pkg::OP_FILT_B;
            bcc_pkg::ST_FILT_C:   cmd.op = bcc_pkg::OP_FILT_C;
            bcc_pkg::ST_INC_A:    cmd.op = bcc_pkg::OP_INC_A;
            bcc_pkg::ST_INC_B:    cmd.op = bcc_pkg::OP_INC_B;
            bcc_pkg::ST_APPLY:    cmd.op = bcc_pkg::OP_APPLY;
            bcc_pkg::ST_CLAMP:    cmd.op = bcc_pkg::OP_CLAMP;
            bcc_pkg::ST_PCT_GO:   cmd.op = bcc_pkg::OP_PCT_GO;
            bcc_pkg::ST_PCT_WAIT: cmd.op = bcc_pkg::OP_PCT_WAIT;
            bcc_pkg::ST_MIN_GO:   cmd.op = bcc_pkg::OP_MIN_GO;
            bcc_pkg::ST_MIN_WAIT: cmd.op = bcc_pkg::OP_MIN_WAIT;
            bcc_pkg::ST_OUT:
            begin
                if (status.out_free)
                    cmd.op = bcc_pkg::OP_OUT;
            end
            default:
            begin
                cmd.op = bcc_pkg::OP_NONE;
            end
        endcase
    end

endmodule

@@ src/battery_coulomb_counter.sv @@
// top level of the coulomb counting fuel gauge
`timescale 1ns / 1ps
// Coulomb counting fuel gauge. Each transaction is a millisecond tick, a
// current and voltage sample, a counter reset or a set of the remaining
// charge, and returns one result with charge in mA*ms, percent and minutes
// left. One transaction is handled at a time. The shared restoring divider
// spends 7 iterations on the percent and 31 on the minutes estimate. A new
// transaction is taken while the previous result waits in the output
// register. Configuration writes take effect at once and belong only in
// idle periods.
module battery_coulomb_counter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           action,
    input  logic [15:0]          voltage_mv,
    input  logic signed [15:0]   current_ma,
    input  logic [15:0]          elapsed_ms,
    input  logic [15:0]          set_value_mah,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 integrated,
    output logic [37:0]          remaining_charge,
    output logic [37:0]          consumed_charge,
    output logic [27:0]          last_increment,
    output logic [6:0]           percent_left,
    output logic signed [15:0]   minutes_left,
    output logic [15:0]          voltage_out_mv,
    output logic signed [15:0]   current_out_ma,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    bcc_pkg::dp_cmd_t    cmd;
    bcc_pkg::dp_status_t status;

    // sequencer
    bcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and storage
    bcc_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .action           (action),
        .voltage_mv       (voltage_mv),
        .current_ma       (current_ma),
        .elapsed_ms       (elapsed_ms),
        .set_value_mah    (set_value_mah),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .integrated       (integrated),
        .remaining_charge (remaining_charge),
        .consumed_charge  (consumed_charge),
        .last_increment   (last_increment),
        .percent_left     (percent_left),
        .minutes_left     (minutes_left),
        .voltage_out_mv   (voltage_out_mv),
        .current_out_ma   (current_out_ma)
    );

endmodule

@@ sim/battery_coulomb_counter_test.sv @@
// self-checking testbench for the coulomb counting fuel gauge
`timescale 1ns / 1ps
module battery_coulomb_counter_test;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 80;
    localparam longint MAH_MS     = 3600000;

    typedef struct {
        logic                integ;
        logic [37:0]         rem;
        logic [37:0]         con;
        logic [27:0]         inc;
        logic [6:0]          pct;
        logic signed [15:0]  mins;
        logic [15:0]         volt;
        logic signed [15:0]  cur;
    } gauge_out_t;

    typedef struct {
        bcc_pkg::action_t    act;
        logic [15:0]         volt;
        logic signed [15:0]  cur;
        logic [15:0]         elapsed;
        logic [15:0]         set_mah;
        bit                  known;
        gauge_out_t          want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] action = '0;
    logic [15:0] voltage_mv = '0;
    logic signed [15:0] current_ma = '0;
    logic [15:0] elapsed_ms = '0;
    logic [15:0] set_value_mah = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic integrated;
    logic [37:0] remaining_charge;
    logic [37:0] consumed_charge;
    logic [27:0] last_increment;
    logic [6:0] percent_left;
    logic signed [15:0] minutes_left;
    logic [15:0] voltage_out_mv;
    logic signed [15:0] current_out_ma;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // gauge model state and register copies
    longint g_cap_mah, g_alpha, g_dead_zone, g_eff_dis, g_eff_chg, g_chg_en;
    bit     g_first;
    longint g_filt, g_remain, g_consumed, g_inc, g_ticks;
    logic [15:0] g_volt;
    logic signed [15:0] g_cur;

    gauge_out_t pending_results[$];
    stim_row_t  dir_rows[$];
    int  error_count = 0;
    bit  idle_on = 1'b1;
    bit  hold_request = 1'b0;
    int  quiet_cycles = 0;

    battery_coulomb_counter u_dut (.*);

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic longint sat_eff(input longint e);
        return (e > 32768) ? 32768 : e;
    endfunction

    // advance the gauge model by one transaction and form its readout
    function automatic gauge_out_t gauge_step(input bcc_pkg::action_t a,
                                               input logic [15:0] v,
                                               input logic signed [15:0] c,
                                               input logic [15:0] e,
                                               input logic [15:0] sv);
        gauge_out_t r;
        longint cap, dt, s, mag, inc, pct, q;
        bit integ;
        cap   = g_cap_mah * MAH_MS;
        integ = 1'b0;
        case (a)
            bcc_pkg::ACT_TICK:
            begin
                if (g_ticks < 8191) g_ticks++;
            end
            bcc_pkg::ACT_SAMPLE:
            begin
                if (g_first)
                begin
                    g_filt  = longint'(c) * 256;
                    g_volt  = v;
                    g_cur   = c;
                    g_inc   = 0;
                    g_ticks = 0;
                    g_first = 1'b0;
                end
                else
                begin
                    dt = e;
                    if (dt == 0) dt = g_ticks;
                    if (dt != 0)
                    begin
                        if (dt > 5000) dt = 5000;
                        s = g_alpha * g_filt + (256 - g_alpha) * longint'(c) * 256 + 128;
                        g_filt = s >>> 8;
                        mag = (g_filt < 0) ? -g_filt : g_filt;
                        inc = 0;
                        if (mag > g_dead_zone * 256)
                        begin
                            if (g_filt > 0)
                            begin
                                inc = (mag * sat_eff(g_eff_dis) * dt) >> 23;
                                g_remain = (g_remain > inc) ? g_remain - inc : 0;
                                g_consumed += inc;
                            end
                            else if (g_chg_en != 0)
                            begin
                                inc = (mag * sat_eff(g_eff_chg) * dt) >> 23;
                                g_remain += inc;
                            end
                        end
                        g_inc = inc & ((longint'(1) << 28) - 1);
                        if (g_remain > cap) g_remain = cap;
                        if (g_consumed > cap) g_consumed = cap;
                        g_volt  = v;
                        g_cur   = c;
                        g_ticks = 0;
                        integ   = 1'b1;
                    end
                end
            end
            bcc_pkg::ACT_RESET:
            begin
                g_remain   = cap;
                g_consumed = 0;
                g_inc      = 0;
                g_ticks    = 0;
                g_first    = 1'b1;
            end
            default:
            begin
                s = longint'(sv) * MAH_MS;
                g_remain   = (s > cap) ? cap : s;
                g_consumed = cap - g_remain;
            end
        endcase

        // percent and minutes readout
        if (cap == 0) pct = 0;
        else
        begin
            pct = g_remain * 100 / cap;
            if (pct > 100) pct = 100;
        end
        mag = (g_filt < 0) ? -g_filt : g_filt;
        if (mag == 0 || mag < g_dead_zone * 256) r.mins = -16'sd1;
        else
        begin
            q = (g_remain << 8) / (mag * 60000);
            if (g_filt > 0) r.mins = (q > 32767) ? 16'sd32767 : 16'(q);
            else r.mins = (q > 32768) ? -16'sd32768 : 16'(-q);
        end
        r.integ = integ;
        r.rem   = 38'(g_remain);
        r.con   = 38'(g_consumed);
        r.inc   = 28'(g_inc);
        r.pct   = 7'(pct);
        r.volt  = g_volt;
        r.cur   = g_cur;
        return r;
    endfunction

    // offer one transaction, with optional idle burst before it
    task automatic send_item(input bcc_pkg::action_t a, input logic [15:0] v,
                             input logic signed [15:0] c, input logic [15:0] e,
                             input logic [15:0] sv, input bit known,
                             input gauge_out_t want);
        gauge_out_t r;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= a;
        voltage_mv    <= v;
        current_ma    <= c;
        elapsed_ms    <= e;
        set_value_mah <= sv;
        do @(posedge clk); while (!in_ready);
        r = gauge_step(a, v, c, e, sv);
        pending_results.push_back(known ? want : r);
    endtask

    // wait until every result is back and the block has settled
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all six registers, block must be idle
    task automatic set_regs(input logic [15:0] cap, input logic [15:0] alpha,
                            input logic [15:0] dz, input logic [15:0] ed,
                            input logic [15:0] ec, input logic [15:0] en);
        logic [15:0] vals [6];
        vals = '{cap, alpha, dz, ed, ec, en};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        g_cap_mah   = cap;
        g_alpha     = (alpha[7:0] < 26) ? 26 : ((alpha[7:0] > 251) ? 251 : alpha[7:0]);
        g_dead_zone = dz[9:0];
        g_eff_dis   = ed;
        g_eff_chg   = ec;
        g_chg_en    = en[0];
    endtask

    // random transaction, mostly samples and ticks
    task automatic send_random();
        bcc_pkg::action_t a;
        logic signed [15:0] c;
        logic [15:0] e, sv;
        int pick;
        gauge_out_t none;
        pick = $urandom_range(0, 99);
        if (pick < 50) a = bcc_pkg::ACT_SAMPLE;
        else if (pick < 85) a = bcc_pkg::ACT_TICK;
        else if (pick < 90) a = bcc_pkg::ACT_RESET;
        else a = bcc_pkg::ACT_SET;
        case ($urandom_range(0, 4))
            0: c = 16'($urandom);
            1: c = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
            2: c = 16'($signed($urandom_range(0, 80)) - 40);
            default: c = 16'($signed($urandom_range(0, 6000)) - 2000);
        endcase
        case ($urandom_range(0, 3))
            0: e = 16'd0;
            1: e = 16'($urandom);
            default: e = 16'($urandom_range(1, 300));
        endcase
        sv = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3000));
        none = '{default: '0};
        send_item(a, 16'($urandom), c, e, sv, 1'b0, none);
    endtask

    task automatic add_row(input bcc_pkg::action_t a, input logic [15:0] v,
                           input logic signed [15:0] c, input logic [15:0] e,
                           input logic [15:0] sv);
        stim_row_t row;
        row = '{a, v, c, e, sv, 1'b0, '{default: '0}};
        dir_rows.push_back(row);
    endtask

    task automatic add_known(input bcc_pkg::action_t a, input logic [15:0] sv,
                             input gauge_out_t want);
        stim_row_t row;
        row = '{a, 16'd0, 16'sd0, 16'd0, sv, 1'b1, want};
        dir_rows.push_back(row);
    endtask

    // result side: check each transaction, then pick next ready
    initial
    begin
        int stall_left;
        gauge_out_t w;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report("unexpected result transaction", 1, 0);
                end
                else
                begin
                    w = pending_results.pop_front();
                    if (integrated !== w.integ) report("integrated", integrated, w.integ);
                    if (remaining_charge !== w.rem)
                        report("remaining_charge", remaining_charge, w.rem);
                    if (consumed_charge !== w.con)
                        report("consumed_charge", consumed_charge, w.con);
                    if (last_increment !== w.inc)
                        report("last_increment", last_increment, w.inc);
                    if (percent_left !== w.pct) report("percent_left", percent_left, w.pct);
                    if (minutes_left !== w.mins) report("minutes_left", minutes_left, w.mins);
                    if (voltage_out_mv !== w.volt)
                        report("voltage_out_mv", voltage_out_mv, w.volt);
                    if (current_out_ma !== w.cur)
                        report("current_out_ma", current_out_ma, w.cur);
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = 300;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0)
                stall_left = $urandom_range(1, 9);
            out_ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        gauge_out_t after_rst, none;
        none = '{default: '0};
        g_cap_mah = 2000; g_alpha = 205; g_dead_zone = 20;
        g_eff_dis = 32768; g_eff_chg = 31785; g_chg_en = 0;
        g_first = 1'b1; g_filt = 0; g_remain = 2000 * MAH_MS; g_consumed = 0;
        g_inc = 0; g_ticks = 0; g_volt = '0; g_cur = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: fixed expectations first, then model-checked rows
        after_rst = '{1'b0, 38'd7200000000, 38'd0, 28'd0, 7'd100, -16'sd1, 16'd0, 16'sd0};
        add_known(bcc_pkg::ACT_TICK, 16'd0, after_rst);
        add_known(bcc_pkg::ACT_SET, 16'd1000,
                  '{1'b0, 38'd3600000000, 38'd3600000000, 28'd0, 7'd50, -16'sd1, 16'd0, 16'sd0});
        add_known(bcc_pkg::ACT_SET, 16'd65535, after_rst);
        add_known(bcc_pkg::ACT_SET, 16'd0,
                  '{1'b0, 38'd0, 38'd7200000000, 28'd0, 7'd0, -16'sd1, 16'd0, 16'sd0});
        add_known(bcc_pkg::ACT_RESET, 16'd0, after_rst);
        add_row(bcc_pkg::ACT_SAMPLE, 16'hFFFF, -16'sd32768, 16'd0, 16'd0);
        add_row(bcc_pkg::ACT_SAMPLE, 16'd0, 16'sd100, 16'd0, 16'd0);
        add_row(bcc_pkg::ACT_TICK, 16'd0, 16'sd0, 16'd0, 16'd0);
        add_row(bcc_pkg::ACT_TICK, 16'd0, 16'sd0, 16'd0, 16'd0);
        add_row(bcc_pkg::ACT_TICK, 16'd0, 16'sd0, 16'd0, 16'd0);
        add_row(bcc_pkg::ACT_SAMPLE, 16'd12345, 16'sd32767, 16'd0, 16'd0);
        add_row(bcc_pkg::ACT_SAMPLE, 16'hFFFF, 16'sd32767, 16'hFFFF, 16'd0);
        add_row(bcc_pkg::ACT_SAMPLE, 16'd3700, -16'sd32768, 16'd1, 16'd0);
        add_row(bcc_pkg::ACT_SAMPLE, 16'd3700, 16'sd10, 16'd100, 16'd0);
        add_row(bcc_pkg::ACT_SAMPLE, 16'd3700, 16'sd0, 16'd5000, 16'd0);
        add_row(bcc_pkg::ACT_SAMPLE, 16'd3700, 16'sd0, 16'd5000, 16'd0);
        add_row(bcc_pkg::ACT_SAMPLE, 16'd3700, 16'sd0, 16'd5000, 16'd0);
        add_row(bcc_pkg::ACT_RESET, 16'd0, 16'sd0, 16'd0, 16'd0);
        add_row(bcc_pkg::ACT_TICK, 16'd0, 16'sd0, 16'd0, 16'd0);
        add_row(bcc_pkg::ACT_SAMPLE, 16'd4000, 16'sd15, 16'd0, 16'd0);
        add_row(bcc_pkg::ACT_SAMPLE, 16'd4000, 16'sd15, 16'd10, 16'd0);
        add_row(bcc_pkg::ACT_SET, 16'd0, 16'sd0, 16'd0, 16'd1);
        foreach (dir_rows[i])
            send_item(dir_rows[i].act, dir_rows[i].volt, dir_rows[i].cur,
                      dir_rows[i].elapsed, dir_rows[i].set_mah, dir_rows[i].known,
                      dir_rows[i].want);

        // run of ticks back to back, then a sample timed by the tick count
        idle_on = 1'b0;
        for (int i = 0; i < 20; i++)
            send_item(bcc_pkg::ACT_TICK, 16'd0, 16'sd0, 16'd0, 16'd0, 1'b0, none);
        send_item(bcc_pkg::ACT_SAMPLE, 16'd3800, 16'sd1000, 16'd0, 16'd0, 1'b0, none);
        idle_on = 1'b1;
        drain();

        // extreme settings: largest capacity, clamped alpha, no dead zone, charging
        set_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd32768, 16'd1);
        for (int i = 0; i < 100; i++)
        begin
            send_random();
            if (i == 20) hold_request = 1'b1;
            if (i == 60) drain();
        end
        drain();

        // other extreme: tiny capacity, low alpha, wide dead zone, zero discharge efficiency
        set_regs(16'd1, 16'd0, 16'd1000, 16'd0, 16'hFFFF, 16'd1);
        for (int i = 0; i < 80; i++) send_random();
        drain();

        // zero capacity reads zero percent
        set_regs(16'd0, 16'd128, 16'd5, 16'd20000, 16'd0, 16'd0);
        for (int i = 0; i < 40; i++) send_random();
        drain();

        // capacity shrink leaves stores above the new capacity
        set_regs(16'd5000, 16'd205, 16'd20, 16'd32768, 16'd31785, 16'd1);
        send_item(bcc_pkg::ACT_SET, 16'd0, 16'sd0, 16'd0, 16'd4000, 1'b0, none);
        drain();
        set_regs(16'd100, 16'd251, 16'd20, 16'd32768, 16'd31785, 16'd1);
        for (int i = 0; i < 100; i++) send_random();
        drain();

        // random settings, last stretch without idling
        for (int p = 0; p < 3; p++)
        begin
            set_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 255)),
                     16'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 1)));
            if (p == 2) idle_on = 1'b0;
            for (int i = 0; i < 70; i++) send_random();
            drain();
        end

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
